[rtl/assert_macros.svh]
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge
`define ATCL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define ATCL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/atcl_pkg.sv]
`timescale 1ns / 1ps

package atcl_pkg;

  // parse phases
  localparam logic [2:0] PhName   = 3'd0;
  localparam logic [2:0] PhEquals = 3'd1;
  localparam logic [2:0] PhRead   = 3'd2;
  localparam logic [2:0] PhTest   = 3'd3;
  localparam logic [2:0] PhWrite  = 3'd4;

  // result kinds
  localparam logic [1:0] KindName    = 2'd0;
  localparam logic [1:0] KindValue   = 2'd1;
  localparam logic [1:0] KindSummary = 2'd2;

  // command modes
  localparam logic [1:0] ModeExecute = 2'd0;
  localparam logic [1:0] ModeRead    = 2'd1;
  localparam logic [1:0] ModeTest    = 2'd2;
  localparam logic [1:0] ModeWrite   = 2'd3;

  // summary status
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusNoMarker = 2'd1;
  localparam logic [1:0] StatusEqAtEnd  = 2'd2;
  localparam logic [1:0] StatusTooLong  = 2'd3;

  // characters
  localparam logic [7:0] CharQuery  = 8'h3F;
  localparam logic [7:0] CharEquals = 8'h3D;
  localparam logic [7:0] Char0      = 8'h30;
  localparam logic [7:0] Char9      = 8'h39;

  // register indexes
  localparam logic RegMarkerBytes  = 1'b0;
  localparam logic RegMarkerLength = 1'b1;

  localparam logic [31:0] MarkerBytesRst  = 32'h0041_542B;
  localparam logic [2:0]  MarkerLengthRst = 3'd3;

  // result queue
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_line;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [1:0]  mode;
    logic [1:0]  status;
    logic [5:0]  name_length;
    logic [31:0] number_value;
    logic        number_valid;
    logic        last;
  } out_rsp_t;

  typedef struct packed {
    logic        marker_found;
    logic [31:0] recent_window;
    logic [2:0]  window_fill;
    logic [2:0]  phase;
    logic [31:0] number_accum;
    logic        digit_seen;
    logic        number_stopped;
  } parse_state_t;

  localparam parse_state_t ParseStateRst = '{
    marker_found:   1'b0,
    recent_window:  32'd0,
    window_fill:    3'd0,
    phase:          PhName,
    number_accum:   32'd0,
    digit_seen:     1'b0,
    number_stopped: 1'b0
  };

  // up to two results per request, res0 goes out first
  typedef struct packed {
    logic [1:0] num;
    out_rsp_t   res0;
    out_rsp_t   res1;
  } res_push_t;

endpackage

[rtl/at_command_line_parser_unit.sv]
// AT command line parser.
// Input channel (in_valid_i/in_ready_o/in_req_i) takes one character per
// request with an end-of-line flag. Output channel (out_valid_o/out_ready_i/
// out_rsp_o) returns name bytes, value bytes and one summary per line.
// Each request is parsed in the cycle it is accepted; its results land in a
// registered four-entry result queue that feeds the output in order.
// Input rate is one request per cycle while the queue holds two entries or
// fewer; the output drains one result per cycle while out_ready_i is high,
// and a line ending on a name or value byte yields two results.
// If the receiver stalls, the queue fills and in_ready_o drops once three
// results are waiting; nothing is lost or reordered.
// Reset clears the parse state, empties the queue and restores the marker
// registers to "AT+" with length three. The APB port writes the marker
// registers (offset 0x0 marker bytes, 0x4 marker length); write them only
// while no line is in progress.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module at_command_line_parser_unit #(
  parameter int unsigned MAX_NAME_LENGTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  atcl_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output atcl_pkg::out_rsp_t out_rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned CntW = $clog2(MAX_NAME_LENGTH + 2);
  localparam logic [CntW-1:0] NameCntLimit = CntW'(MAX_NAME_LENGTH + 1);

  logic [31:0] marker_bytes_q;
  logic [2:0]  marker_length_q;
  logic        cfg_wr;

  atcl_pkg::parse_state_t state_q, state_d;
  logic [CntW-1:0] name_count_q, name_count_d;
  atcl_pkg::res_push_t push;
  logic in_acc;
  logic out_acc;
  logic [atcl_pkg::FifoCntW-1:0] fifo_count;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_bytes_q  <= atcl_pkg::MarkerBytesRst;
      marker_length_q <= atcl_pkg::MarkerLengthRst;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        atcl_pkg::RegMarkerBytes:  marker_bytes_q  <= pwdata;
        atcl_pkg::RegMarkerLength: marker_length_q <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      atcl_pkg::RegMarkerBytes:  prdata = marker_bytes_q;
      atcl_pkg::RegMarkerLength: prdata = {29'd0, marker_length_q};
      default:                   prdata = '0;
    endcase
  end

  // room for the worst case of two results per request
  assign in_ready_o = fifo_count <= atcl_pkg::FifoCntW'(atcl_pkg::FifoDepth - 2);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_o && out_ready_i;

  atcl_parser #(
    .MAX_NAME_LENGTH(MAX_NAME_LENGTH),
    .CntW           (CntW)
  ) u_parser (
    .marker_bytes_i (marker_bytes_q),
    .marker_length_i(marker_length_q),
    .in_req_i       (in_req_i),
    .st_i           (state_q),
    .name_count_i   (name_count_q),
    .st_o           (state_d),
    .name_count_o   (name_count_d),
    .push_o         (push)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= atcl_pkg::ParseStateRst;
      name_count_q <= '0;
    end else if (in_acc) begin
      state_q      <= state_d;
      name_count_q <= name_count_d;
    end
  end

  atcl_result_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_en_i(in_acc),
    .push_i   (push),
    .pop_i    (out_acc),
    .head_o   (out_rsp_o),
    .valid_o  (out_valid_o),
    .count_o  (fifo_count)
  );

  `ATCL_ASSERT_NEXT(a_eol_clears_line, in_acc && in_req_i.end_of_line,
    !state_q.marker_found && (name_count_q == '0), "line state not cleared after end of line")

  `ATCL_ASSERT(a_last_only_on_summary,
    !out_valid_o || (out_rsp_o.last == (out_rsp_o.kind == atcl_pkg::KindSummary)),
    "last flag does not match summary kind")

  `ATCL_ASSERT(a_name_count_bound, name_count_q <= NameCntLimit,
    "name count beyond saturation")

  `ATCL_ASSERT(a_fifo_no_overflow,
    fifo_count <= atcl_pkg::FifoCntW'(atcl_pkg::FifoDepth), "result queue overflow")

endmodule

[rtl/atcl_parser.sv]
`timescale 1ns / 1ps

module atcl_parser #(
  parameter int unsigned MAX_NAME_LENGTH = 32,
  parameter int unsigned CntW            = 6
) (
  input  logic [31:0]          marker_bytes_i,
  input  logic [2:0]           marker_length_i,
  input  atcl_pkg::in_req_t    in_req_i,
  input  atcl_pkg::parse_state_t st_i,
  input  logic [CntW-1:0]      name_count_i,
  output atcl_pkg::parse_state_t st_o,
  output logic [CntW-1:0]      name_count_o,
  output atcl_pkg::res_push_t  push_o
);

  localparam logic [CntW-1:0] MaxCnt   = CntW'(MAX_NAME_LENGTH);
  localparam logic [CntW-1:0] MaxCntP1 = CntW'(MAX_NAME_LENGTH + 1);

  logic [7:0]       c;
  logic             eol;
  logic [2:0]       len;
  logic [31:0]      mask;
  logic [31:0]      win;
  logic [2:0]       fill;
  logic             is_digit;
  logic [31:0]      acc_next;
  logic             eq_at_end;
  logic             byte_vld;
  logic             too_long;
  logic [CntW-1:0]  nlen;
  logic [CntW+5:0]  nlen_ext;
  atcl_pkg::out_rsp_t byte_res;
  atcl_pkg::out_rsp_t sum_res;
  atcl_pkg::parse_state_t st_d;
  logic [CntW-1:0]  cnt_d;

  assign c   = in_req_i.char_byte;
  assign eol = in_req_i.end_of_line;

  always_comb begin
    unique case (marker_length_i)
      3'd0:                   len = 3'd1;
      3'd1, 3'd2, 3'd3, 3'd4: len = marker_length_i;
      default:                len = 3'd4;
    endcase
  end

  always_comb begin
    unique case (len)
      3'd1:    mask = 32'h0000_00FF;
      3'd2:    mask = 32'h0000_FFFF;
      3'd3:    mask = 32'h00FF_FFFF;
      default: mask = 32'hFFFF_FFFF;
    endcase
  end

  assign win      = {st_i.recent_window[23:0], c};
  assign fill     = (st_i.window_fill < 3'd4) ? st_i.window_fill + 3'd1 : st_i.window_fill;
  assign is_digit = (c >= atcl_pkg::Char0) && (c <= atcl_pkg::Char9);
  // times ten as two shifts
  assign acc_next = (st_i.number_accum << 3) + (st_i.number_accum << 1)
                  + {24'd0, c - atcl_pkg::Char0};

  always_comb begin
    st_d      = st_i;
    cnt_d     = name_count_i;
    eq_at_end = 1'b0;
    byte_vld  = 1'b0;
    byte_res  = '0;
    if (!st_i.marker_found) begin
      st_d.recent_window = win;
      st_d.window_fill   = fill;
      if ((fill >= len) && ((win & mask) == (marker_bytes_i & mask))) begin
        st_d.marker_found = 1'b1;
      end
    end else begin
      unique case (st_i.phase)
        atcl_pkg::PhName: begin
          priority if (c == atcl_pkg::CharQuery) begin
            st_d.phase = atcl_pkg::PhRead;
          end else if (c == atcl_pkg::CharEquals) begin
            if (eol) begin
              eq_at_end = 1'b1;
            end else begin
              st_d.phase = atcl_pkg::PhEquals;
            end
          end else if (name_count_i < MaxCnt) begin
            cnt_d             = name_count_i + 1'b1;
            byte_vld          = 1'b1;
            byte_res.kind     = atcl_pkg::KindName;
            byte_res.out_byte = c;
          end else begin
            cnt_d = MaxCntP1;
          end
        end
        atcl_pkg::PhEquals, atcl_pkg::PhWrite: begin
          if ((st_i.phase == atcl_pkg::PhEquals) && (c == atcl_pkg::CharQuery)) begin
            st_d.phase = atcl_pkg::PhTest;
          end else begin
            st_d.phase = atcl_pkg::PhWrite;
            if (!st_i.number_stopped) begin
              if (is_digit) begin
                st_d.number_accum = acc_next;
                st_d.digit_seen   = 1'b1;
              end else begin
                st_d.number_stopped = 1'b1;
              end
            end
            byte_vld          = 1'b1;
            byte_res.kind     = atcl_pkg::KindValue;
            byte_res.out_byte = c;
          end
        end
        default: ;
      endcase
    end
  end

  assign too_long = cnt_d > MaxCnt;
  assign nlen     = too_long ? MaxCnt : cnt_d;
  assign nlen_ext = {6'd0, nlen};

  always_comb begin
    sum_res      = '0;
    sum_res.kind = atcl_pkg::KindSummary;
    sum_res.last = 1'b1;
    if (!st_d.marker_found) begin
      sum_res.status = atcl_pkg::StatusNoMarker;
    end else if (eq_at_end) begin
      sum_res.status      = atcl_pkg::StatusEqAtEnd;
      sum_res.name_length = nlen_ext[5:0];
    end else begin
      sum_res.name_length = nlen_ext[5:0];
      sum_res.status      = too_long ? atcl_pkg::StatusTooLong : atcl_pkg::StatusOk;
      unique case (st_d.phase)
        atcl_pkg::PhRead: sum_res.mode = atcl_pkg::ModeRead;
        atcl_pkg::PhTest: sum_res.mode = atcl_pkg::ModeTest;
        atcl_pkg::PhWrite: begin
          sum_res.mode         = atcl_pkg::ModeWrite;
          sum_res.number_value = st_d.number_accum;
          sum_res.number_valid = st_d.digit_seen;
        end
        default: sum_res.mode = atcl_pkg::ModeExecute;
      endcase
    end
  end

  always_comb begin
    push_o = '0;
    if (byte_vld) begin
      push_o.res0 = byte_res;
      push_o.res1 = sum_res;
      push_o.num  = eol ? 2'd2 : 2'd1;
    end else begin
      push_o.res0 = sum_res;
      push_o.num  = eol ? 2'd1 : 2'd0;
    end
  end

  // the line state starts over after each end of line
  assign st_o         = eol ? atcl_pkg::ParseStateRst : st_d;
  assign name_count_o = eol ? '0 : cnt_d;

endmodule

[rtl/atcl_result_fifo.sv]
`timescale 1ns / 1ps

module atcl_result_fifo (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_en_i,
  input  atcl_pkg::res_push_t               push_i,
  input  logic                              pop_i,
  output atcl_pkg::out_rsp_t                head_o,
  output logic                              valid_o,
  output logic [atcl_pkg::FifoCntW-1:0]     count_o
);

  atcl_pkg::out_rsp_t mem_q [atcl_pkg::FifoDepth];
  logic [atcl_pkg::FifoPtrW-1:0] wp_q, wp_d, rp_q, rp_d, wp_next;
  logic [atcl_pkg::FifoCntW-1:0] cnt_q, cnt_d;
  logic [1:0] push_num;

  assign push_num = push_en_i ? push_i.num : 2'd0;
  assign wp_next  = wp_q + 1'b1;
  assign wp_d     = wp_q + atcl_pkg::FifoPtrW'(push_num);
  assign rp_d     = rp_q + atcl_pkg::FifoPtrW'(pop_i);
  assign cnt_d    = cnt_q + atcl_pkg::FifoCntW'(push_num) - atcl_pkg::FifoCntW'(pop_i);

  always_ff @(posedge clk_i) begin
    if (push_num != 2'd0) begin
      mem_q[wp_q] <= push_i.res0;
    end
    if (push_num == 2'd2) begin
      mem_q[wp_next] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  assign head_o  = mem_q[rp_q];
  assign valid_o = cnt_q != '0;
  assign count_o = cnt_q;

endmodule
